[rtl/core/clcd_pkg.sv]
// Package with the item types, opcodes and constants of the character-LCD write sequencer.
package clcd_pkg;

	// Request opcodes.
	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_CMD    = 3'd1;
	localparam logic [2:0] OP_DATA   = 3'd2;
	localparam logic [2:0] OP_STRING = 3'd3;
	localparam logic [2:0] OP_NUMBER = 3'd4;
	localparam logic [2:0] OP_GOTO   = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_BUS_MODE = 1'b0;
	localparam logic CFG_WRAP_POS = 1'b1;

	// Fixed display commands and values.
	localparam logic [7:0] CMD_FUNC_8BIT   = 8'h3C;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_SECOND_LINE = 8'hC0;
	localparam logic [7:0] NIB_FUNC_4BIT   = 8'h02;
	localparam logic [7:0] NIB_FUNC_LINES  = 8'h08;
	localparam logic [7:0] ROW1_OFFSET     = 8'h40;
	localparam logic [7:0] DDRAM_SET       = 8'h80;
	localparam logic [7:0] ASCII_ZERO      = 8'd48;
	localparam logic [7:0] WRAP_RESET      = 8'd40;

	// Reciprocal of ten for the divide step: floor(n / 10) = (n * RECIP10) >> 35.
	localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
	localparam int          RECIP10_SHIFT = 35;
	localparam int          MAX_DIGITS    = 10;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  byte_value;
		logic        first_of_string;
		logic [31:0] number_value;
		logic [7:0]  column;
		logic [7:0]  row;
	} in_item_t;

	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_value;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_EMIT
	} state_t;

endpackage

[rtl/core/clcd_div10.sv]
// Shared divide-by-ten unit: registered reciprocal multiply, quotient and remainder formed from it.
module clcd_div10 (
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] dividend,
	output logic [28:0] quotient,
	output logic [3:0]  remainder
);
	import clcd_pkg::*;

	logic [63:0] prod_q;
	logic [31:0] dvd_q;
	logic [31:0] times_ten;
	logic [31:0] diff;

	// Multiply by the reciprocal and keep the dividend for the remainder.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= {32'd0, dividend} * {32'd0, RECIP10};
			dvd_q  <= dividend;
		end
	end

	// Quotient from the high product bits; remainder is dividend minus ten times it.
	always_comb begin
		quotient  = prod_q[63:RECIP10_SHIFT];
		times_ten = {quotient, 3'b000} + {2'b00, quotient, 1'b0};
		diff      = dvd_q - times_ten;
		remainder = diff[3:0];
	end

endmodule

[rtl/core/character_lcd_write_sequencer.sv]
// Top level of the character-LCD write sequencer.
//
// Each request on the in channel becomes a series of LCD enable pulses on the
// out channel, one item per pulse, with last set on the final pulse of the
// request. An item is taken when valid is high and stall is low on a channel.
// The block takes one request at a time: in_stall is high from acceptance
// until the final pulse has been loaded into the output register; the next
// request may then be taken while that pulse still waits at the output.
// Pulses leave at one per cycle when out_stall stays low. A byte costs one
// pulse on the eight-bit bus and two on the four-bit bus.
// A number request first runs one divide-by-ten step per digit through the
// shared reciprocal multiplier, a multiply state then a fix state each, so a
// ten-digit number gives 10 or 20 pulses after its division. Other requests
// go to the pulse state straight from acceptance and take 1 to 7 pulses.
// Unused opcodes produce no pulses and leave the block idle again next cycle.
// A stall on the out side holds the current pulse and pauses the sequence.
// Reset returns to idle with the four-bit bus, wrap position 40 and the string
// count at zero. Configuration writes are always ready and take effect at once.
module character_lcd_write_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  clcd_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output clcd_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);
	import clcd_pkg::*;

	state_t      state_q, state_d;

	logic        bus_mode_q;
	logic [7:0]  wrap_pos_q;
	logic [7:0]  str_count_q;

	logic [2:0]  op_q;
	logic [7:0]  byte_q;
	logic [7:0]  addr_q;
	logic [31:0] num_q;
	logic [3:0]  digits_q [MAX_DIGITS];
	logic [3:0]  nd_q;
	logic [3:0]  elem_cnt_q;
	logic [3:0]  elem_idx_q;
	logic        half_q;

	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_accept;
	logic        div_load;
	logic [28:0] div_quot;
	logic [3:0]  div_rem;
	logic        emit_pulse;
	logic        div_done;

	logic [3:0]  elem_cnt_d;
	logic [7:0]  next_count;
	logic [7:0]  goto_addr;

	logic        elem_rs;
	logic [7:0]  elem_val;
	logic        elem_single;
	logic [3:0]  digit_idx;
	logic        pulse_advance;
	logic        pulse_last;
	logic [7:0]  pulse_val;

	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Shared divide unit.
	clcd_div10 u_div10 (
		.clk       (clk),
		.load      (div_load),
		.dividend  (num_q),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q <= 1'b1;
			wrap_pos_q <= WRAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BUS_MODE: bus_mode_q <= cfg_data[0];
				CFG_WRAP_POS: wrap_pos_q <= cfg_data;
				default:      bus_mode_q <= bus_mode_q;
			endcase
		end
	end

	// Values derived from the incoming request.
	always_comb begin
		next_count = (in_data.first_of_string ? 8'd0 : str_count_q) + 8'd1;
		if (in_data.row == 8'd0) begin
			goto_addr = in_data.column;
		end else if (in_data.row == 8'd1) begin
			goto_addr = in_data.column + ROW1_OFFSET;
		end else begin
			goto_addr = 8'd0;
		end
		goto_addr = goto_addr | DDRAM_SET;

		case (in_data.opcode)
			OP_INIT:   elem_cnt_d = bus_mode_q ? 4'd5 : 4'd3;
			OP_STRING: elem_cnt_d = (next_count == wrap_pos_q) ? 4'd2 : 4'd1;
			default:   elem_cnt_d = 4'd1;
		endcase
	end

	// Current list element: register select, value and whether it is a single raw pulse.
	always_comb begin
		elem_rs     = 1'b0;
		elem_val    = 8'd0;
		elem_single = !bus_mode_q;
		digit_idx   = nd_q - 4'd1 - elem_idx_q;
		case (op_q)
			OP_INIT: begin
				if (bus_mode_q) begin
					case (elem_idx_q)
						4'd0, 4'd1: begin
							elem_val    = NIB_FUNC_4BIT;
							elem_single = 1'b1;
						end
						4'd2: begin
							elem_val    = NIB_FUNC_LINES;
							elem_single = 1'b1;
						end
						4'd3:    elem_val = CMD_DISPLAY_ON;
						default: elem_val = CMD_CLEAR;
					endcase
				end else begin
					case (elem_idx_q)
						4'd0:    elem_val = CMD_FUNC_8BIT;
						4'd1:    elem_val = CMD_DISPLAY_ON;
						default: elem_val = CMD_CLEAR;
					endcase
				end
			end
			OP_CMD: elem_val = byte_q;
			OP_DATA: begin
				elem_rs  = 1'b1;
				elem_val = byte_q;
			end
			OP_STRING: begin
				if (elem_idx_q == 4'd0) begin
					elem_rs  = 1'b1;
					elem_val = byte_q;
				end else begin
					elem_val = CMD_SECOND_LINE;
				end
			end
			OP_NUMBER: begin
				elem_rs  = 1'b1;
				elem_val = ASCII_ZERO + {4'd0, digits_q[digit_idx]};
			end
			OP_GOTO: elem_val = addr_q;
			default: elem_val = 8'd0;
		endcase
	end

	// Pulse formation: whole byte, high nibble or low nibble.
	always_comb begin
		if (elem_single) begin
			pulse_val     = elem_val;
			pulse_advance = 1'b1;
		end else if (!half_q) begin
			pulse_val     = {4'd0, elem_val[7:4]};
			pulse_advance = 1'b0;
		end else begin
			pulse_val     = {4'd0, elem_val[3:0]};
			pulse_advance = 1'b1;
		end
		pulse_last = pulse_advance && (elem_idx_q == elem_cnt_q - 4'd1);
		div_done   = (div_quot == 29'd0) || (nd_q == 4'(MAX_DIGITS - 1));
	end

	// Sequencer: next state and control strobes.
	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		div_load   = 1'b0;
		emit_pulse = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_data.opcode == OP_NUMBER) begin
						state_d = ST_MUL;
					end else if (in_data.opcode <= OP_GOTO) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_MUL: begin
				div_load = 1'b1;
				state_d  = ST_FIX;
			end
			ST_FIX: begin
				state_d = div_done ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_pulse = 1'b1;
					if (pulse_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// String character count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_count_q <= 8'd0;
		end else if (in_accept && in_data.opcode == OP_STRING) begin
			str_count_q <= next_count;
		end
	end

	// Request fields, digit store and element walk.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q       <= in_data.opcode;
			byte_q     <= in_data.byte_value;
			addr_q     <= goto_addr;
			num_q      <= in_data.number_value;
			nd_q       <= 4'd0;
			elem_cnt_q <= elem_cnt_d;
			elem_idx_q <= 4'd0;
			half_q     <= 1'b0;
		end else if (state_q == ST_FIX) begin
			digits_q[nd_q] <= div_rem;
			nd_q           <= nd_q + 4'd1;
			num_q          <= {3'd0, div_quot};
			elem_cnt_q     <= nd_q + 4'd1;
		end else if (emit_pulse) begin
			if (pulse_advance) begin
				elem_idx_q <= elem_idx_q + 4'd1;
				half_q     <= 1'b0;
			end else begin
				half_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_pulse) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_pulse) begin
			out_q.reg_select <= elem_rs;
			out_q.bus_value  <= pulse_val;
			out_q.last       <= pulse_last;
		end
	end

endmodule
